// ----- hw/rtl/csvt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV tokenizer package
// Parse modes, special characters and the structs shared by the tokenizer.
// ----------------------------------------------------------------------------
package csvt_pkg;

	// Special characters of the text.
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	// Parse modes. Codes above MODE_AFTERQ behave as line start.
	typedef enum logic [2:0] {
		MODE_LINE   = 3'd0,
		MODE_LINECR = 3'd1,
		MODE_FSTART = 3'd2,
		MODE_UNQ    = 3'd3,
		MODE_QUO    = 3'd4,
		MODE_AFTERQ = 3'd5
	} mode_t;

	// Parser state carried from one byte to the next.
	typedef struct packed {
		mode_t mode;
		logic  cr_pending;
	} parse_state_t;

	// One result item.
	typedef struct packed {
		logic       held_cr_out;
		logic       data_valid;
		logic [7:0] data_byte;
		logic       field_end;
		logic       record_end;
		logic       open_quote_error;
	} result_t;

endpackage

// ----- hw/rtl/csvt_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV tokenizer step logic
// Combinational decode of one text byte against the current parse state:
// gives the next state and the result for that byte.
// ----------------------------------------------------------------------------
module csvt_step (
	input  logic [7:0]            text_byte,
	input  logic                  final_byte,
	input  csvt_pkg::parse_state_t cur,
	output csvt_pkg::parse_state_t nxt,
	output csvt_pkg::result_t     res
);

	logic is_nl;
	logic is_cr;
	logic is_comma;
	logic is_quote;

	assign is_nl    = (text_byte == csvt_pkg::CH_NL);
	assign is_cr    = (text_byte == csvt_pkg::CH_CR);
	assign is_comma = (text_byte == csvt_pkg::CH_COMMA);
	assign is_quote = (text_byte == csvt_pkg::CH_QUOTE);

	// Per-mode byte handling, then the end-of-text close.
	always_comb begin
		nxt = cur;
		res = '0;
		case (cur.mode)
			csvt_pkg::MODE_LINECR: begin
				if (is_nl) begin
					nxt.cr_pending = 1'b0;
					res.record_end = 1'b1;
					nxt.mode       = csvt_pkg::MODE_LINE;
				end else if (is_cr) begin
					res.held_cr_out = 1'b1;
					nxt.cr_pending  = 1'b1;
					nxt.mode        = csvt_pkg::MODE_UNQ;
				end else if (is_comma) begin
					res.held_cr_out = cur.cr_pending;
					nxt.cr_pending  = 1'b0;
					res.field_end   = 1'b1;
					nxt.mode        = csvt_pkg::MODE_FSTART;
				end else begin
					res.held_cr_out = cur.cr_pending;
					nxt.cr_pending  = 1'b0;
					res.data_valid  = 1'b1;
					res.data_byte   = text_byte;
					nxt.mode        = csvt_pkg::MODE_UNQ;
				end
			end
			csvt_pkg::MODE_FSTART: begin
				if (is_nl) begin
					res.field_end  = 1'b1;
					res.record_end = 1'b1;
					nxt.mode       = csvt_pkg::MODE_LINE;
				end else if (is_quote) begin
					nxt.mode = csvt_pkg::MODE_QUO;
				end else if (is_comma) begin
					res.field_end = 1'b1;
				end else if (is_cr) begin
					nxt.cr_pending = 1'b1;
					nxt.mode       = csvt_pkg::MODE_UNQ;
				end else begin
					res.data_valid = 1'b1;
					res.data_byte  = text_byte;
					nxt.mode       = csvt_pkg::MODE_UNQ;
				end
			end
			csvt_pkg::MODE_UNQ, csvt_pkg::MODE_QUO: begin
				if (is_nl) begin
					nxt.cr_pending       = 1'b0;
					res.field_end        = 1'b1;
					res.record_end       = 1'b1;
					res.open_quote_error = (cur.mode == csvt_pkg::MODE_QUO);
					nxt.mode             = csvt_pkg::MODE_LINE;
				end else if (is_cr) begin
					// A second carriage return releases the one already held.
					res.held_cr_out = cur.cr_pending;
					nxt.cr_pending  = 1'b1;
				end else if (cur.mode == csvt_pkg::MODE_UNQ && is_comma) begin
					res.held_cr_out = cur.cr_pending;
					nxt.cr_pending  = 1'b0;
					res.field_end   = 1'b1;
					nxt.mode        = csvt_pkg::MODE_FSTART;
				end else if (cur.mode == csvt_pkg::MODE_QUO && is_quote) begin
					res.held_cr_out = cur.cr_pending;
					nxt.cr_pending  = 1'b0;
					nxt.mode        = csvt_pkg::MODE_AFTERQ;
				end else begin
					res.held_cr_out = cur.cr_pending;
					nxt.cr_pending  = 1'b0;
					res.data_valid  = 1'b1;
					res.data_byte   = text_byte;
				end
			end
			csvt_pkg::MODE_AFTERQ: begin
				// Bytes after a closing quote are dropped up to comma or newline.
				if (is_nl) begin
					res.field_end  = 1'b1;
					res.record_end = 1'b1;
					nxt.mode       = csvt_pkg::MODE_LINE;
				end else if (is_comma) begin
					res.field_end = 1'b1;
					nxt.mode      = csvt_pkg::MODE_FSTART;
				end
			end
			default: begin
				nxt.mode       = csvt_pkg::MODE_LINE;
				nxt.cr_pending = 1'b0;
				if (is_quote) begin
					nxt.mode = csvt_pkg::MODE_QUO;
				end else if (is_comma) begin
					res.field_end = 1'b1;
					nxt.mode      = csvt_pkg::MODE_FSTART;
				end else if (is_cr) begin
					nxt.cr_pending = 1'b1;
					nxt.mode       = csvt_pkg::MODE_LINECR;
				end else if (!is_nl) begin
					res.data_valid = 1'b1;
					res.data_byte  = text_byte;
					nxt.mode       = csvt_pkg::MODE_UNQ;
				end
			end
		endcase

		// The last byte of the text closes any open field and record.
		if (final_byte) begin
			nxt.cr_pending = 1'b0;
			if (nxt.mode == csvt_pkg::MODE_LINECR) begin
				res.record_end = 1'b1;
			end else if (nxt.mode != csvt_pkg::MODE_LINE) begin
				res.field_end  = 1'b1;
				res.record_end = 1'b1;
				if (nxt.mode == csvt_pkg::MODE_QUO) begin
					res.open_quote_error = 1'b1;
				end
			end
			nxt.mode = csvt_pkg::MODE_LINE;
		end
	end

endmodule

// ----- hw/rtl/csv_field_tokenizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV field tokenizer
// Splits CSV text, one byte per transfer, into content bytes and field and
// record end marks, one result per byte.
// ----------------------------------------------------------------------------
// The tokenizer takes one byte per clock when not stalled and gives one result
// per byte: the byte is captured in an input register, decoded against the
// parse state in one pass of short logic, and the result lands in an output
// register. The parse state advances once per byte, which is what sets the
// sustained rate of one byte every cycle while res_stall is low. The output
// register holds a result under res_stall while the input register keeps the
// next byte, so a stall reaches src_stall only when both are full.
module csv_field_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	output logic       src_stall,
	input  logic [7:0] text_byte,
	input  logic       final_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       held_cr_out,
	output logic       data_valid,
	output logic [7:0] data_byte,
	output logic       field_end,
	output logic       record_end,
	output logic       open_quote_error
);

	logic                   valid_s1;
	logic [7:0]             text_byte_s1;
	logic                   final_byte_s1;
	logic                   valid_s2;
	csvt_pkg::result_t      res_s2;
	csvt_pkg::parse_state_t state_q;
	csvt_pkg::parse_state_t state_nxt;
	csvt_pkg::result_t      res_nxt;
	logic                   out_free;
	logic                   s1_adv;
	logic                   s1_free;

	// Flow control between the two register stages.
	assign out_free  = !valid_s2 || !res_stall;
	assign s1_adv    = valid_s1 && out_free;
	assign s1_free   = !valid_s1 || out_free;
	assign src_stall = !s1_free;

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= src_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (s1_free && src_valid) begin
			text_byte_s1  <= text_byte;
			final_byte_s1 <= final_byte;
		end
	end

	// Byte decode.
	csvt_step u_step (
		.text_byte  (text_byte_s1),
		.final_byte (final_byte_s1),
		.cur        (state_q),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	// Parse state and output valid advance when a byte moves into the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode       <= csvt_pkg::MODE_LINE;
			state_q.cr_pending <= 1'b0;
			valid_s2           <= 1'b0;
		end else begin
			if (s1_adv) begin
				state_q <= state_nxt;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_s2 <= res_nxt;
		end
	end

	assign res_valid        = valid_s2;
	assign held_cr_out      = res_s2.held_cr_out;
	assign data_valid       = res_s2.data_valid;
	assign data_byte        = res_s2.data_byte;
	assign field_end        = res_s2.field_end;
	assign record_end       = res_s2.record_end;
	assign open_quote_error = res_s2.open_quote_error;

	// An unclosed quote is only ever reported together with a closed record.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && open_quote_error) |-> (record_end && field_end))
		else $error("open quote flag without record end");

	// Content-free results carry a zero byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !data_valid) |-> (data_byte == 8'd0))
		else $error("nonzero data byte without data valid");

	// A carriage return is held only in modes that can release it.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.cr_pending |-> (state_q.mode == csvt_pkg::MODE_LINECR ||
			state_q.mode == csvt_pkg::MODE_UNQ || state_q.mode == csvt_pkg::MODE_QUO))
		else $error("carriage return held in wrong mode");

	// The last byte of the text leaves the parser at line start.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && final_byte_s1) |=>
			(state_q.mode == csvt_pkg::MODE_LINE && !state_q.cr_pending))
		else $error("parser not reset after final byte");

endmodule
